FILE: src/chpt_pkg.sv
// ----------------------------------------------------------------------------
// chpt_pkg
// Shared types and defaults for the convex half-plane point test unit.
// ----------------------------------------------------------------------------
package chpt_pkg;

  // Default sizes of the vertex buffer, the constraint table and coordinates.
  localparam int MAX_VERTICES_DEF = 16;
  localparam int MAX_ROWS_DEF     = 64;
  localparam int COORD_BITS_DEF   = 24;

  // Operation codes carried by each input beat.
  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_VERTEX   = 2'd1,
    OP_QUERY    = 2'd2,
    OP_RESERVED = 2'd3
  } op_e;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;    // register a new product
    logic acc_load;  // move the current product into the accumulator
  } mac_ctrl_t;

endpackage

FILE: src/chpt_ram.sv
// ----------------------------------------------------------------------------
// chpt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled.
// ----------------------------------------------------------------------------
module chpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/chpt_mac.sv
// ----------------------------------------------------------------------------
// chpt_mac
// Shared signed multiplier with a registered product and an accumulator.
// The sum output adds the held product to the accumulator.
// ----------------------------------------------------------------------------
module chpt_mac
  import chpt_pkg::*;
#(
  parameter int OP_W  = 25,
  parameter int ACC_W = 52
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [OP_W-1:0]  a_i,
  input  logic signed [OP_W-1:0]  b_i,
  input  mac_ctrl_t               ctrl_i,
  output logic signed [ACC_W-1:0] sum_o
);

  localparam int PROD_W = 2 * OP_W;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = ACC_W'(prod_q);

  // Product register and accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      if (ctrl_i.mul_en) begin
        prod_q <= a_i * b_i;
      end
      if (ctrl_i.acc_load) begin
        acc_q <= prod_ext;
      end
    end
  end

  assign sum_o = acc_q + prod_ext;

endmodule

FILE: src/convex_halfplane_point_test_unit.sv
// ----------------------------------------------------------------------------
// convex_halfplane_point_test_unit
// Keeps a table of half-plane constraints built from convex polygons and
// tests query points against all of them.
// ----------------------------------------------------------------------------
// One item is handled at a time and every item returns exactly one result
// beat. A vertex marked last that closes a ring of n vertices makes four
// passes per edge through the single shared multiplier to build and orient
// its constraint. A query reads table rows up to and including the first
// violated row, or to the end of the table; each row costs one multiplier
// pass per coordinate and a compare. The input is stalled until the result
// sits in the output register; a finished result waits there without
// blocking the next item.
// ----------------------------------------------------------------------------
module convex_halfplane_point_test_unit
  import chpt_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_ROWS     = MAX_ROWS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic signed [COORD_BITS-1:0]  x_coord_i,
  input  logic signed [COORD_BITS-1:0]  y_coord_i,
  input  logic                          last_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          contained_o,
  output logic                          status_o,
  output logic [$clog2(MAX_ROWS+1)-1:0] rows_in_use_o
);

  localparam int C      = COORD_BITS;
  localparam int NW     = C + 1;           // normal component width
  localparam int BW     = 2 * C + 3;       // stored offset width
  localparam int ACC_W  = 2 * C + 4;       // accumulator width
  localparam int ROW_W  = 2 * NW + BW;
  localparam int VTX_W  = 2 * C;
  localparam int RW     = $clog2(MAX_ROWS + 1);
  localparam int TA     = $clog2(MAX_ROWS);
  localparam int VW     = $clog2(MAX_VERTICES + 1);
  localparam int VA     = $clog2(MAX_VERTICES);
  localparam int SUM_W  = ((RW > VW) ? RW : VW) + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CSTART,
    S_CFIRST,
    S_CEDGE,
    S_CM1,
    S_CM2,
    S_CM3,
    S_CM4,
    S_CCMP,
    S_QM1,
    S_QM2,
    S_QCMP,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  // Control counters.
  logic [VW-1:0] vtx_cnt_q, vtx_cnt_d;
  logic [VW-1:0] n_q, n_d;
  logic [VW-1:0] eidx_q, eidx_d;
  logic [RW-1:0] row_cnt_q, row_cnt_d;
  logic [RW-1:0] ridx_q, ridx_d;

  // Geometry registers.
  logic signed [C-1:0]     xmin_q, xmin_d, xmax_q, xmax_d;
  logic signed [C-1:0]     ymin_q, ymin_d, ymax_q, ymax_d;
  logic signed [NW-1:0]    cx2_q, cx2_d, cy2_q, cy2_d;
  logic signed [C-1:0]     x1_q, x1_d, y1_q, y1_d;
  logic signed [C-1:0]     x2_q, x2_d, y2_q, y2_d;
  logic signed [NW-1:0]    ax_q, ax_d, ay_q, ay_d;
  logic signed [ACC_W-1:0] b_q, b_d;
  logic signed [C-1:0]     qx_q, qx_d, qy_q, qy_d;

  // Result and output registers.
  logic          res_cont_q, res_cont_d;
  logic          res_stat_q, res_stat_d;
  logic          out_valid_q, out_valid_d;
  logic          out_cont_q, out_cont_d;
  logic          out_stat_q, out_stat_d;
  logic [RW-1:0] out_rows_q, out_rows_d;

  // Memory ports.
  logic             vtx_we, vtx_re;
  logic [VA-1:0]    vtx_waddr, vtx_raddr;
  logic [VTX_W-1:0] vtx_wdata, vtx_rdata;
  logic             tab_we, tab_re;
  logic [TA-1:0]    tab_waddr, tab_raddr;
  logic [ROW_W-1:0] tab_wdata, tab_rdata;

  // Shared multiplier.
  mac_ctrl_t               mac_ctrl;
  logic signed [NW-1:0]    mac_a, mac_b;
  logic signed [ACC_W-1:0] mac_sum;

  // Decoded fields.
  logic signed [C-1:0]  rd_x, rd_y;
  logic signed [NW-1:0] row_nx, row_ny;
  logic signed [BW-1:0] row_b;
  op_e                  op;
  logic                 vtx_full;
  logic                 tab_ovf;
  logic                 flip;
  logic signed [NW-1:0] nx_st, ny_st;
  logic signed [ACC_W-1:0] b_st;
  logic [VW:0]          j_wide;
  logic [VA-1:0]        j_next;
  logic [RW-1:0]        ridx_inc;

  assign rd_x   = $signed(vtx_rdata[VTX_W-1:C]);
  assign rd_y   = $signed(vtx_rdata[C-1:0]);
  assign row_b  = $signed(tab_rdata[BW-1:0]);
  assign row_ny = $signed(tab_rdata[BW +: NW]);
  assign row_nx = $signed(tab_rdata[BW+NW +: NW]);

  assign op       = op_e'(opcode_i);
  assign vtx_full = (vtx_cnt_q == VW'(MAX_VERTICES));
  assign tab_ovf  = (SUM_W'(row_cnt_q) + SUM_W'(vtx_cnt_q) + SUM_W'(1)) > SUM_W'(MAX_ROWS);

  // Orientation: flip when the doubled centre lies outside the edge line.
  assign flip  = mac_sum > (b_q <<< 1);
  assign nx_st = flip ? -ax_q : ax_q;
  assign ny_st = flip ? -ay_q : ay_q;
  assign b_st  = flip ? -b_q : b_q;

  // Second vertex of the next edge, wrapping to the first vertex.
  assign j_wide   = (VW+1)'(eidx_q) + (VW+1)'(2);
  assign j_next   = (j_wide == (VW+1)'(n_q)) ? '0 : j_wide[VA-1:0];
  assign ridx_inc = ridx_q + RW'(1);

  // Multiplier operand selection.
  always_comb begin
    mac_a    = '0;
    mac_b    = '0;
    mac_ctrl = '0;
    unique case (state_q)
      S_CM1: begin
        mac_a           = ax_q;
        mac_b           = NW'(x1_q);
        mac_ctrl.mul_en = 1'b1;
      end
      S_CM2: begin
        mac_a             = ay_q;
        mac_b             = NW'(y1_q);
        mac_ctrl.mul_en   = 1'b1;
        mac_ctrl.acc_load = 1'b1;
      end
      S_CM3: begin
        mac_a           = ax_q;
        mac_b           = cx2_q;
        mac_ctrl.mul_en = 1'b1;
      end
      S_CM4: begin
        mac_a             = ay_q;
        mac_b             = cy2_q;
        mac_ctrl.mul_en   = 1'b1;
        mac_ctrl.acc_load = 1'b1;
      end
      S_QM1: begin
        mac_a           = row_nx;
        mac_b           = NW'(qx_q);
        mac_ctrl.mul_en = 1'b1;
      end
      S_QM2: begin
        mac_a             = row_ny;
        mac_b             = NW'(qy_q);
        mac_ctrl.mul_en   = 1'b1;
        mac_ctrl.acc_load = 1'b1;
      end
      S_IDLE, S_CSTART, S_CFIRST, S_CEDGE, S_CCMP, S_QCMP, S_FINISH: begin
        mac_ctrl = '0;
      end
    endcase
  end

  // Sequencer next-state and datapath logic.
  always_comb begin
    state_d     = state_q;
    vtx_cnt_d   = vtx_cnt_q;
    n_d         = n_q;
    eidx_d      = eidx_q;
    row_cnt_d   = row_cnt_q;
    ridx_d      = ridx_q;
    xmin_d      = xmin_q;
    xmax_d      = xmax_q;
    ymin_d      = ymin_q;
    ymax_d      = ymax_q;
    cx2_d       = cx2_q;
    cy2_d       = cy2_q;
    x1_d        = x1_q;
    y1_d        = y1_q;
    x2_d        = x2_q;
    y2_d        = y2_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    b_d         = b_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    res_cont_d  = res_cont_q;
    res_stat_d  = res_stat_q;
    out_cont_d  = out_cont_q;
    out_stat_d  = out_stat_q;
    out_rows_d  = out_rows_q;
    out_valid_d = out_valid_q && out_stall_i;

    vtx_we    = 1'b0;
    vtx_waddr = vtx_cnt_q[VA-1:0];
    vtx_wdata = {x_coord_i, y_coord_i};
    vtx_re    = 1'b0;
    vtx_raddr = '0;
    tab_we    = 1'b0;
    tab_waddr = row_cnt_q[TA-1:0];
    tab_wdata = {nx_st, ny_st, BW'(b_st)};
    tab_re    = 1'b0;
    tab_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_cont_d = 1'b0;
          res_stat_d = 1'b0;
          state_d    = S_FINISH;
          unique case (op)
            OP_CLEAR: begin
              row_cnt_d = '0;
            end
            OP_VERTEX: begin
              if (vtx_full) begin
                res_stat_d = 1'b1;
                if (last_vertex_i) begin
                  vtx_cnt_d = '0;
                end
              end else begin
                // The first vertex of a ring loads the bounding box.
                if (vtx_cnt_q == '0) begin
                  xmin_d = x_coord_i;
                  xmax_d = x_coord_i;
                  ymin_d = y_coord_i;
                  ymax_d = y_coord_i;
                end else begin
                  if (x_coord_i < xmin_q) xmin_d = x_coord_i;
                  if (x_coord_i > xmax_q) xmax_d = x_coord_i;
                  if (y_coord_i < ymin_q) ymin_d = y_coord_i;
                  if (y_coord_i > ymax_q) ymax_d = y_coord_i;
                end
                vtx_we    = 1'b1;
                vtx_cnt_d = vtx_cnt_q + VW'(1);
                if (last_vertex_i) begin
                  vtx_cnt_d = '0;
                  if (tab_ovf) begin
                    res_stat_d = 1'b1;
                  end else begin
                    n_d     = vtx_cnt_q + VW'(1);
                    eidx_d  = '0;
                    state_d = S_CSTART;
                  end
                end
              end
            end
            OP_QUERY: begin
              qx_d       = x_coord_i;
              qy_d       = y_coord_i;
              res_cont_d = 1'b1;
              if (row_cnt_q != '0) begin
                ridx_d    = '0;
                tab_re    = 1'b1;
                tab_raddr = '0;
                state_d   = S_QM1;
              end
            end
            OP_RESERVED: begin
              res_cont_d = 1'b0;
            end
          endcase
        end
      end

      // Doubled bounding-box centre, and fetch of the first vertex.
      S_CSTART: begin
        cx2_d     = NW'(xmin_q) + NW'(xmax_q);
        cy2_d     = NW'(ymin_q) + NW'(ymax_q);
        vtx_re    = 1'b1;
        vtx_raddr = '0;
        state_d   = S_CFIRST;
      end

      S_CFIRST: begin
        x1_d      = rd_x;
        y1_d      = rd_y;
        vtx_re    = 1'b1;
        vtx_raddr = (n_q == VW'(1)) ? '0 : VA'(1);
        state_d   = S_CEDGE;
      end

      // Edge normal from the pair of vertices.
      S_CEDGE: begin
        x2_d    = rd_x;
        y2_d    = rd_y;
        ax_d    = NW'(rd_y) - NW'(y1_q);
        ay_d    = NW'(x1_q) - NW'(rd_x);
        state_d = S_CM1;
      end

      S_CM1: begin
        state_d = S_CM2;
      end

      S_CM2: begin
        state_d = S_CM3;
      end

      S_CM3: begin
        b_d     = mac_sum;
        state_d = S_CM4;
      end

      S_CM4: begin
        state_d = S_CCMP;
      end

      // Store the oriented constraint and move on to the next edge.
      S_CCMP: begin
        tab_we    = 1'b1;
        row_cnt_d = row_cnt_q + RW'(1);
        x1_d      = x2_q;
        y1_d      = y2_q;
        if (eidx_q == n_q - VW'(1)) begin
          state_d = S_FINISH;
        end else begin
          eidx_d    = eidx_q + VW'(1);
          vtx_re    = 1'b1;
          vtx_raddr = j_next;
          state_d   = S_CEDGE;
        end
      end

      S_QM1: begin
        state_d = S_QM2;
      end

      S_QM2: begin
        state_d = S_QCMP;
      end

      // A violated row ends the query early.
      S_QCMP: begin
        if (mac_sum > ACC_W'(row_b)) begin
          res_cont_d = 1'b0;
          state_d    = S_FINISH;
        end else if (ridx_inc == row_cnt_q) begin
          state_d = S_FINISH;
        end else begin
          ridx_d    = ridx_inc;
          tab_re    = 1'b1;
          tab_raddr = ridx_inc[TA-1:0];
          state_d   = S_QM1;
        end
      end

      // Hand the result to the output register once it is free.
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_cont_d  = res_cont_q;
          out_stat_d  = res_stat_q;
          out_rows_d  = row_cnt_q;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  // State and registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vtx_cnt_q   <= '0;
      n_q         <= '0;
      eidx_q      <= '0;
      row_cnt_q   <= '0;
      ridx_q      <= '0;
      xmin_q      <= '0;
      xmax_q      <= '0;
      ymin_q      <= '0;
      ymax_q      <= '0;
      cx2_q       <= '0;
      cy2_q       <= '0;
      x1_q        <= '0;
      y1_q        <= '0;
      x2_q        <= '0;
      y2_q        <= '0;
      ax_q        <= '0;
      ay_q        <= '0;
      b_q         <= '0;
      qx_q        <= '0;
      qy_q        <= '0;
      res_cont_q  <= 1'b0;
      res_stat_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_cont_q  <= 1'b0;
      out_stat_q  <= 1'b0;
      out_rows_q  <= '0;
    end else begin
      state_q     <= state_d;
      vtx_cnt_q   <= vtx_cnt_d;
      n_q         <= n_d;
      eidx_q      <= eidx_d;
      row_cnt_q   <= row_cnt_d;
      ridx_q      <= ridx_d;
      xmin_q      <= xmin_d;
      xmax_q      <= xmax_d;
      ymin_q      <= ymin_d;
      ymax_q      <= ymax_d;
      cx2_q       <= cx2_d;
      cy2_q       <= cy2_d;
      x1_q        <= x1_d;
      y1_q        <= y1_d;
      x2_q        <= x2_d;
      y2_q        <= y2_d;
      ax_q        <= ax_d;
      ay_q        <= ay_d;
      b_q         <= b_d;
      qx_q        <= qx_d;
      qy_q        <= qy_d;
      res_cont_q  <= res_cont_d;
      res_stat_q  <= res_stat_d;
      out_valid_q <= out_valid_d;
      out_cont_q  <= out_cont_d;
      out_stat_q  <= out_stat_d;
      out_rows_q  <= out_rows_d;
    end
  end

  // Vertex buffer: x and y of each buffered vertex in one word.
  chpt_ram #(
    .WIDTH(VTX_W),
    .DEPTH(MAX_VERTICES)
  ) u_vtx_ram (
    .clk_i  (clk_i),
    .we_i   (vtx_we),
    .waddr_i(vtx_waddr),
    .wdata_i(vtx_wdata),
    .re_i   (vtx_re),
    .raddr_i(vtx_raddr),
    .rdata_o(vtx_rdata)
  );

  // Constraint table: normal x, normal y and offset of each row.
  chpt_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_ROWS)
  ) u_tab_ram (
    .clk_i  (clk_i),
    .we_i   (tab_we),
    .waddr_i(tab_waddr),
    .wdata_i(tab_wdata),
    .re_i   (tab_re),
    .raddr_i(tab_raddr),
    .rdata_o(tab_rdata)
  );

  // Shared multiply-accumulate unit.
  chpt_mac #(
    .OP_W (NW),
    .ACC_W(ACC_W)
  ) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .ctrl_i(mac_ctrl),
    .sum_o (mac_sum)
  );

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign contained_o   = out_cont_q;
  assign status_o      = out_stat_q;
  assign rows_in_use_o = out_rows_q;

endmodule

FILE: src/chpt_checker.sv
// ----------------------------------------------------------------------------
// chpt_checker
// Port-level checks of the convex half-plane point test unit, bound to the
// top level.
// ----------------------------------------------------------------------------
module chpt_checker #(
  parameter int MAX_ROWS = 64
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          contained_o,
  input logic                          status_o,
  input logic [$clog2(MAX_ROWS+1)-1:0] rows_in_use_o
);

  // The table never reports more rows than it can hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rows_in_use_o <= MAX_ROWS))
  else $error("rows_in_use exceeds table depth");

  // Only a query reports containment, and a query never flags overflow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && contained_o) |-> !status_o)
  else $error("contained and overflow reported in one beat");

  // One item at a time: an accepted beat stalls the input in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
  else $error("input not stalled after an accepted beat");

  // A stalled result beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(contained_o) && $stable(status_o) && $stable(rows_in_use_o)))
  else $error("stalled result beat changed");

endmodule

bind convex_halfplane_point_test_unit chpt_checker #(
  .MAX_ROWS(MAX_ROWS)
) u_chpt_checker (.*);
